FILE: rtl/vpsg_pkg.sv
// vpsg_pkg: shared constants for the VAR(p) step generator
// field widths, stream layout, mode and register codes
// no dependencies
`timescale 1ns / 1ps

package vpsg_pkg;

	// number of series lanes, also the coefficient row stride
	localparam int LANES = 4;
	localparam int WORD_W = 32;
	localparam int EXO_MAX = 2;

	// input stream layout, tdata fields from the lowest bit
	localparam int SLOT_W = 7;
	localparam int MODE_W = 2;
	localparam int IN_DATA_W = 232;
	localparam int OUT_DATA_W = LANES * WORD_W;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 3;

	// item kinds carried in tuser
	localparam logic [MODE_W-1:0] MODE_COEF = 2'd0;
	localparam logic [MODE_W-1:0] MODE_START = 2'd1;
	localparam logic [MODE_W-1:0] MODE_STEP = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LAG_ORDER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_USE_CONST = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_USE_TREND = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXO_COLS = 3'd4;

endpackage

FILE: rtl/vpsg_ram.sv
// vpsg_ram: generic single-port-write, single-port-read ram
// read data registered
// no dependencies
`timescale 1ns / 1ps

module vpsg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/var_process_step_generator.sv
// var_process_step_generator: multichannel VAR(p) generator in Q16.16
// uses vpsg_pkg and one vpsg_ram per lane for the coefficient store
//
// channel | handshake          | tdata (low bit up)                      | tuser
// s       | s_tvalid/s_tready  | slot_index, load_word, noise_0..3,     | mode
//         |                    | exo_0, exo_1, one pad bit               |
// m       | m_tvalid/m_tready  | y_0, y_1, y_2, y_3                      | saturated
// cfg     | cfg_we             | cfg_index, cfg_wdata                    | -
//
// load items are taken while idle. a step item reads one coefficient row
// a cycle, four multiply-accumulate lanes in parallel, through the ram read,
// multiply, round and accumulate stages into the result register, over rows =
// use_constant + use_trend + exo_columns + lag_order * channels_in_use rows.
// reset clears registers, history and step count; the coefficient store is not
// cleared. a finished result waits in the output register until taken.
`timescale 1ns / 1ps

module var_process_step_generator
	import vpsg_pkg::*;
#(
	parameter int LAG_MAX = 4,
	parameter int COEF_DEPTH = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// slot_index[6:0], load_word[38:7], noise_0..3[166:39], exo_0, exo_1[230:167]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// mode[1:0]
	input  logic [MODE_W-1:0]     s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// y_0[31:0], y_1[63:32], y_2[95:64], y_3[127:96]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// saturated[0]
	output logic                  m_tuser,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int ROWS = COEF_DEPTH / LANES;
	localparam int AW = $clog2(ROWS);
	localparam int HIST_DEPTH = LAG_MAX * LANES;
	localparam int HW = $clog2(HIST_DEPTH);
	localparam int LW = (LAG_MAX > 1) ? $clog2(LAG_MAX) + 1 : 1;
	localparam int PW = $clog2(LAG_MAX + 1);
	localparam int NROWS_MAX = 2 + EXO_MAX + LAG_MAX * LANES;
	localparam int RW = $clog2(NROWS_MAX + 1);
	localparam int ACC_W = 56;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;
	typedef enum logic [1:0] {TK_CONST, TK_TREND, TK_EXO, TK_LAG} term_kind_t;

	state_t state_q;

	// configuration registers
	logic [2:0] lag_order_q, channels_q;
	logic       use_const_q, use_trend_q;
	logic [1:0] exo_cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lag_order_q <= 3'd1;
			channels_q  <= 3'd4;
			use_const_q <= 1'b0;
			use_trend_q <= 1'b0;
			exo_cols_q  <= 2'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LAG_ORDER: lag_order_q <= cfg_wdata;
				REG_CHANNELS:  channels_q  <= cfg_wdata;
				REG_USE_CONST: use_const_q <= cfg_wdata[0];
				REG_USE_TREND: use_trend_q <= cfg_wdata[0];
				REG_EXO_COLS:  exo_cols_q  <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// clamped configuration and row plan
	logic [PW-1:0] p_eff;
	logic [2:0]    kk;
	logic [1:0]    nx;
	logic [RW-1:0] exo_base, endo_base, nrows;

	always_comb begin
		if (lag_order_q == 3'd0) p_eff = PW'(1);
		else if (int'(lag_order_q) > LAG_MAX) p_eff = PW'(LAG_MAX);
		else p_eff = PW'(lag_order_q);
		if (channels_q == 3'd0) kk = 3'd1;
		else if (channels_q > 3'(LANES)) kk = 3'(LANES);
		else kk = channels_q;
		nx = (exo_cols_q > 2'(EXO_MAX)) ? 2'(EXO_MAX) : exo_cols_q;
		exo_base  = RW'(use_const_q) + RW'(use_trend_q);
		endo_base = exo_base + RW'(nx);
		nrows     = endo_base + RW'(p_eff) * RW'(kk);
	end

	// input fields
	logic [SLOT_W-1:0]       slot;
	logic signed [WORD_W-1:0] load_word;
	logic signed [WORD_W-1:0] noise [LANES];
	logic signed [WORD_W-1:0] exo_in [EXO_MAX];

	assign slot      = s_tdata[SLOT_W-1:0];
	assign load_word = s_tdata[SLOT_W +: WORD_W];
	for (genvar j = 0; j < LANES; j++) begin : g_noise
		assign noise[j] = s_tdata[SLOT_W + WORD_W * (j + 1) +: WORD_W];
	end
	for (genvar c = 0; c < EXO_MAX; c++) begin : g_exo
		assign exo_in[c] = s_tdata[SLOT_W + WORD_W * (LANES + 1 + c) +: WORD_W];
	end

	logic s_accept;
	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;

	// coefficient store, one ram per lane, addressed by row
	logic                     coef_wr;
	logic [LANES-1:0]         lane_we;
	logic [RW-1:0]            row_q;
	logic signed [WORD_W-1:0] coef_rd [LANES];

	assign coef_wr = s_accept && (s_tuser == MODE_COEF) && (int'(slot) < COEF_DEPTH);

	for (genvar j = 0; j < LANES; j++) begin : g_lane_ram
		assign lane_we[j] = coef_wr && (slot[1:0] == 2'(j));
		vpsg_ram #(.WIDTH(WORD_W), .DEPTH(ROWS)) u_ram (
			.clk   (clk),
			.we    (lane_we[j]),
			.waddr (AW'(slot[SLOT_W-1:2])),
			.wdata (load_word),
			.raddr (AW'(row_q)),
			.rdata (coef_rd[j])
		);
	end

	// term being issued this cycle
	logic signed [WORD_W-1:0] hist_q [HIST_DEPTH];
	logic signed [WORD_W-1:0] exo_q [EXO_MAX];
	logic [15:0]              step_q;
	logic [LW-1:0]            lag_q;
	logic [1:0]               ch_q;
	term_kind_t               kind;
	logic signed [WORD_W-1:0] mult;
	logic [RW-1:0]            exo_sel;

	always_comb begin
		exo_sel = row_q - exo_base;
		if (row_q < RW'(use_const_q)) begin
			kind = TK_CONST;
			mult = WORD_W'(1);
		end else if (row_q < exo_base) begin
			kind = TK_TREND;
			mult = WORD_W'(step_q);
		end else if (row_q < endo_base) begin
			kind = TK_EXO;
			mult = exo_q[exo_sel[0]];
		end else begin
			kind = TK_LAG;
			mult = hist_q[HW'({lag_q, ch_q})];
		end
	end

	// pipeline: ram read, multiply, round, accumulate
	logic                     v_s1, v_s2, v_s3;
	logic                     rnd_s1, rnd_s2, zero_s1;
	logic signed [WORD_W-1:0] mult_s1;
	logic signed [63:0]       prod_s2 [LANES];
	logic signed [ACC_W-1:0]  term_s3 [LANES];
	logic signed [ACC_W-1:0]  acc_q [LANES];
	logic                     issue;

	assign issue = (state_q == ST_RUN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		// stage 1: multiplicand aligned with ram data
		mult_s1 <= mult;
		rnd_s1  <= (kind == TK_EXO) || (kind == TK_LAG);
		zero_s1 <= (int'(row_q) >= ROWS);
		rnd_s2  <= rnd_s1;
		for (int j = 0; j < LANES; j++) begin
			// stage 2: product, out-of-range rows read as zero
			prod_s2[j] <= zero_s1 ? 64'sd0 : coef_rd[j] * mult_s1;
			// stage 3: round to nearest, ties up, or keep exact
			if (rnd_s2) term_s3[j] <= ACC_W'((prod_s2[j] + 64'sd32768) >>> 16);
			else term_s3[j] <= ACC_W'(prod_s2[j]);
			// accumulate, start value is the noise sample
			if (s_accept) acc_q[j] <= ACC_W'(noise[j]);
			else if (v_s3) acc_q[j] <= acc_q[j] + term_s3[j];
		end
	end

	// saturation of the finished sums
	logic signed [WORD_W-1:0] y [LANES];
	logic [LANES-1:0]         lane_sat;

	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			lane_sat[j] = 1'b0;
			y[j] = '0;
			if (3'(j) < kk) begin
				if (acc_q[j] > ACC_W'(64'sd2147483647)) begin
					y[j] = 32'sh7fffffff;
					lane_sat[j] = 1'b1;
				end else if (acc_q[j] < ACC_W'(-64'sd2147483648)) begin
					y[j] = 32'sh80000000;
					lane_sat[j] = 1'b1;
				end else begin
					y[j] = WORD_W'(acc_q[j]);
				end
			end
		end
	end

	logic finish;
	assign finish = (state_q == ST_DRAIN) && !v_s1 && !v_s2 && !v_s3 &&
		(!m_tvalid || m_tready);

	// sequencer, history, step count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			row_q    <= '0;
			lag_q    <= '0;
			ch_q     <= '0;
			step_q   <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tuser  <= 1'b0;
			for (int i = 0; i < HIST_DEPTH; i++) hist_q[i] <= '0;
			for (int c = 0; c < EXO_MAX; c++) exo_q[c] <= '0;
		end else begin
			if (m_tvalid && m_tready && !finish) m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					row_q <= '0;
					lag_q <= '0;
					ch_q  <= '0;
					if (s_accept) begin
						case (s_tuser)
							MODE_START: begin
								if (int'(slot) < HIST_DEPTH) hist_q[HW'(slot)] <= load_word;
								step_q <= '0;
							end
							MODE_STEP: begin
								if (step_q != 16'hffff) step_q <= step_q + 16'd1;
								for (int c = 0; c < EXO_MAX; c++) exo_q[c] <= exo_in[c];
								state_q <= ST_RUN;
							end
							default: ;
						endcase
					end
				end
				ST_RUN: begin
					// walk the coefficient rows, lag counters follow the lag rows
					if (kind == TK_LAG) begin
						if (3'(ch_q) == kk - 3'd1) begin
							ch_q  <= '0;
							lag_q <= lag_q + LW'(1);
						end else begin
							ch_q <= ch_q + 2'd1;
						end
					end
					if (row_q == nrows - RW'(1)) state_q <= ST_DRAIN;
					else row_q <= row_q + RW'(1);
				end
				ST_DRAIN: begin
					if (finish) begin
						for (int i = HIST_DEPTH - 1; i >= LANES; i--) hist_q[i] <= hist_q[i - LANES];
						for (int j = 0; j < LANES; j++) begin
							hist_q[j] <= y[j];
							m_tdata[WORD_W * j +: WORD_W] <= y[j];
						end
						m_tuser  <= |lane_sat;
						m_tvalid <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: verif/tb.sv
// tb: self-checking bench for var_process_step_generator
// holds a Q16.16 VAR(p) step predictor in a small scoreboard class; plain tasks drive the stream
// depends on rtl/vpsg_pkg.sv, rtl/vpsg_ram.sv and rtl/var_process_step_generator.sv
`timescale 1ns / 1ps

module tb;
	import vpsg_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASES = 12;
	localparam int ITEMS_PER_PHASE = 170;

	// item kind that the block must ignore
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [SLOT_W-1:0] slot;
		logic [31:0] word;
		logic [3:0][31:0] noise;
		logic [1:0][31:0] exo;
	} var_item_t;

	typedef struct packed {
		logic [3:0][31:0] y;
		logic sat;
	} var_out_t;

	// predicts each step result from its own copy of store, history and registers
	class var_step_tracker;
		logic signed [31:0] coefs [128];
		logic signed [31:0] hist [16];
		int unsigned step_cnt;
		logic [2:0] r_lag, r_chan;
		logic r_const, r_trend;
		logic [1:0] r_exo;
		var_out_t pending_y [$];
		int errors;
		int steps_checked;
		int loads;

		function new();
			foreach (coefs[i]) coefs[i] = 0;
			foreach (hist[i]) hist[i] = 0;
			step_cnt = 0;
			r_lag = 1;
			r_chan = 4;
			r_const = 0;
			r_trend = 0;
			r_exo = 0;
			errors = 0;
			steps_checked = 0;
			loads = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_LAG_ORDER: r_lag = val;
				REG_CHANNELS: r_chan = val;
				REG_USE_CONST: r_const = val[0];
				REG_USE_TREND: r_trend = val[0];
				REG_EXO_COLS: r_exo = val[1:0];
				default: ;
			endcase
		endfunction

		function longint coef_at(int row, int col);
			int a;
			a = row * LANES + col;
			if (a >= 128)
				return 0;
			return longint'(coefs[a]);
		endfunction

		// product rounded to nearest, ties upward
		function longint qmul(longint a, longint b);
			longint w;
			w = a * b + 64'sh8000;
			return w >>> 16;
		endfunction

		function void note_item(var_item_t it);
			int p, kc, nx, eb, endo;
			longint acc;
			var_out_t r;
			case (it.mode)
				MODE_COEF: begin
					coefs[it.slot] = it.word;
					loads++;
				end
				MODE_START: begin
					if (it.slot < 16)
						hist[it.slot] = it.word;
					step_cnt = 0;
					loads++;
				end
				MODE_STEP: begin
					p = (r_lag == 0) ? 1 : (r_lag > 4 ? 4 : r_lag);
					kc = (r_chan == 0) ? 1 : (r_chan > 4 ? 4 : r_chan);
					nx = (r_exo > 2) ? 2 : r_exo;
					eb = r_const + r_trend;
					endo = eb + nx;
					if (step_cnt < 65535)
						step_cnt++;
					r = '0;
					for (int j = 0; j < 4; j++) begin
						if (j < kc) begin
							acc = longint'($signed(it.noise[j]));
							if (r_const)
								acc += coef_at(0, j);
							if (r_trend)
								acc += longint'(step_cnt) * coef_at(r_const, j);
							for (int c = 0; c < nx; c++)
								acc += qmul(longint'($signed(it.exo[c])), coef_at(eb + c, j));
							for (int l = 0; l < p; l++)
								for (int k = 0; k < kc; k++)
									acc += qmul(coef_at(endo + k + kc * l, j),
										longint'(hist[l * 4 + k]));
							if (acc > 64'sd2147483647) begin
								acc = 64'sd2147483647;
								r.sat = 1'b1;
							end else if (acc < -64'sd2147483648) begin
								acc = -64'sd2147483648;
								r.sat = 1'b1;
							end
							r.y[j] = acc[31:0];
						end
					end
					// shift history, newest lag first
					for (int l = 3; l > 0; l--)
						for (int k = 0; k < 4; k++)
							hist[l * 4 + k] = hist[(l - 1) * 4 + k];
					for (int k = 0; k < 4; k++)
						hist[k] = r.y[k];
					pending_y.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void check_output(var_out_t got);
			var_out_t want;
			if (pending_y.size() == 0) begin
				$display("%0t: unexpected result y=%h sat=%b", $time, got.y, got.sat);
				errors++;
				return;
			end
			want = pending_y.pop_front();
			steps_checked++;
			for (int j = 0; j < 4; j++)
				if (want.y[j] !== got.y[j]) begin
					$display("%0t: y_%0d expected %h actual %h", $time, j, want.y[j], got.y[j]);
					errors++;
				end
			if (want.sat !== got.sat) begin
				$display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic [MODE_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	var_step_tracker sb;
	int tx_idle;
	int rx_idle;
	int cycles;

	var_process_step_generator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// 8 ns clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side: check taken items, then choose the next ready level
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_output({m_tdata, m_tuser});
		m_tready <= arst_n && ($urandom_range(0, 99) >= rx_idle);
	end

	// send one item, with random idle cycles ahead of it
	task automatic send_item(var_item_t it);
		while ($urandom_range(0, 99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.mode;
		s_tdata <= {1'b0, it.exo, it.noise, it.word, it.slot};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_item(it);
	endtask

	// wait until every result is back and the block has settled
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending_y.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	// unused upper bits of the single-bit and exo registers get random values, and an unused index gets a random write
	task automatic apply_setting(int lag, int chan, int uc, int ut, int ex);
		drain();
		write_reg(REG_LAG_ORDER, CFG_DATA_W'(lag));
		write_reg(REG_CHANNELS, CFG_DATA_W'(chan));
		write_reg(REG_USE_CONST, CFG_DATA_W'(uc | ($urandom_range(0, 3) << 1)));
		write_reg(REG_USE_TREND, CFG_DATA_W'(ut | ($urandom_range(0, 3) << 1)));
		write_reg(REG_EXO_COLS, CFG_DATA_W'(ex | ($urandom_range(0, 1) << 2)));
		write_reg(CFG_IDX_W'($urandom_range(5, 7)), CFG_DATA_W'($urandom_range(0, 7)));
	endtask

	// mostly small Q16.16 values, sometimes any 32-bit word
	function automatic logic [31:0] rand_word(int wide_pct, int half_span);
		if ($urandom_range(0, 99) < wide_pct)
			return $urandom;
		return $urandom_range(0, 2 * half_span) - half_span;
	endfunction

	function automatic var_item_t rand_step();
		var_item_t it;
		it.mode = MODE_STEP;
		it.slot = SLOT_W'($urandom_range(0, 127));
		it.word = $urandom;
		for (int j = 0; j < 4; j++)
			it.noise[j] = rand_word(8, 262144);
		for (int c = 0; c < 2; c++)
			it.exo[c] = rand_word(8, 131072);
		return it;
	endfunction

	function automatic var_item_t load_item(logic [MODE_W-1:0] md, int slot,
		logic [31:0] w);
		var_item_t it;
		it = rand_step();
		it.mode = md;
		it.slot = SLOT_W'(slot);
		it.word = w;
		return it;
	endfunction

	task automatic random_items(int n);
		int r;
		var_item_t it;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 62)
				it = rand_step();
			else if (r < 78)
				it = load_item(MODE_COEF, $urandom_range(0, 127), rand_word(10, 16384));
			else if (r < 92)
				it = load_item(MODE_START,
					($urandom_range(0, 9) < 8) ? $urandom_range(0, 15) : $urandom_range(16, 127),
					rand_word(10, 262144));
			else
				it = load_item(MODE_UNUSED, $urandom_range(0, 127), $urandom);
			send_item(it);
		end
	endtask

	int settings [PHASES][5] = '{
		'{1, 4, 0, 0, 0}, '{4, 4, 1, 1, 2}, '{1, 1, 1, 1, 0}, '{0, 0, 1, 0, 3},
		'{7, 7, 0, 1, 1}, '{2, 3, 1, 1, 2}, '{3, 2, 0, 0, 1}, '{4, 1, 1, 0, 2},
		'{5, 4, 1, 1, 3}, '{1, 2, 0, 1, 0}, '{4, 4, 0, 0, 0}, '{2, 4, 1, 1, 2}
	};

	initial begin
		var_item_t it;
		sb = new();
		cycles = 0;
		tx_idle = 9;
		rx_idle = 58;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// fill the whole coefficient store so no read hits an unwritten word
		for (int a = 0; a < 128; a++)
			send_item(load_item(MODE_COEF, a, rand_word(0, 16384)));

		// directed: extremes, ignored writes, unknown mode, trend restart
		apply_setting(4, 4, 1, 1, 2);
		send_item(load_item(MODE_COEF, 0, 32'h7fffffff));
		send_item(load_item(MODE_COEF, 1, 32'h80000000));
		send_item(load_item(MODE_START, 0, 32'h7fffffff));
		send_item(load_item(MODE_START, 5, 32'h80000000));
		send_item(load_item(MODE_START, 15, 32'hffffffff));
		send_item(load_item(MODE_START, 16, 32'h12345678));
		send_item(load_item(MODE_START, 127, 32'hffffffff));
		it = rand_step();
		it.noise = {4{32'h7fffffff}};
		it.exo = {2{32'h7fffffff}};
		send_item(it);
		it.noise = {4{32'h80000000}};
		it.exo = {2{32'h80000000}};
		send_item(it);
		send_item(load_item(MODE_UNUSED, 127, 32'hffffffff));
		it = rand_step();
		it.noise = '0;
		it.exo = '0;
		send_item(it);
		send_item(load_item(MODE_COEF, 127, 32'h5a5a5a5a));
		send_item(load_item(MODE_COEF, 0, 32'h00010000));
		send_item(load_item(MODE_COEF, 1, 32'hffff0000));
		for (int s = 0; s < 4; s++)
			send_item(load_item(MODE_START, s, 32'h0));
		repeat (3) send_item(rand_step());

		// random phases over the register settings and idling regimes
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < 4) begin
				tx_idle = 9;
				rx_idle = 58;
			end else if (ph < 8) begin
				tx_idle = 58;
				rx_idle = 9;
			end else begin
				tx_idle = 0;
				rx_idle = 0;
			end
			apply_setting(settings[ph][0], settings[ph][1], settings[ph][2],
				settings[ph][3], settings[ph][4]);
			random_items(ITEMS_PER_PHASE);
		end

		drain();
		$display("covered %0d register settings, %0d load items, %0d step results checked",
			PHASES + 1, sb.loads, sb.steps_checked);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
